[hw/rtl/isset_pkg.sv]
`default_nettype none

package isset_pkg;

  // Number of entry cells in the store.
  localparam int unsigned CAPACITY = 128;

  // Widths of the element, the held count and the reported count.
  localparam int unsigned ElemW  = 32;
  localparam int unsigned OccW   = $clog2(CAPACITY + 1);
  localparam int unsigned CountW = 8;
  localparam int unsigned PfxSteps = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Largest count the store can report: the capacity, capped at 255.
  localparam int unsigned CountMax = (CAPACITY > 255) ? 255 : CAPACITY;

  // Request codes; the unused code acts as a membership query.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_type_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_PFX  = 2'd2,
    ST_UPD  = 2'd3
  } state_e;

  // One request.
  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [ElemW-1:0] elem;
  } req_t;

  // One result.
  typedef struct packed {
    logic              was_present;
    logic              dropped_full;
    logic [CountW-1:0] count;
  } res_t;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/isset_cell.sv]
`default_nettype none

module isset_cell
  import isset_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [ElemW-1:0] elem_i,
  input  wire logic             prev_valid_i,
  input  wire logic [ElemW-1:0] next_entry_i,
  input  wire logic             next_valid_i,
  input  wire logic             shift_i,
  output logic [ElemW-1:0]      entry_o,
  output logic                  valid_o,
  output logic                  match_o
);

  logic [ElemW-1:0] entry_q, entry_d;
  logic             valid_q, valid_d;
  logic             match_q, match_d;

  // Local compare against the broadcast element.
  assign match_d = ctrl_i.cmp_en ? (valid_q && (entry_q == elem_i)) : match_q;

  // A delete shifts the upper neighbor down; an insert fills the first free cell.
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.del_en && shift_i) begin
      entry_d = next_entry_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.ins_en && prev_valid_i && !valid_q) begin
      entry_d = elem_i;
      valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

[hw/rtl/isset_pfx.sv]
`default_nettype none

module isset_pfx
  import isset_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic [CAPACITY-1:0] match_i,
  output logic [CAPACITY-1:0]      pfx_o
);

  logic [CAPACITY-1:0] pfx_q, pfx_d;
  logic [CAPACITY-1:0] scan;

  // Log-depth prefix OR: bit i is set when any cell at or below i matched.
  always_comb begin
    scan = match_i;
    for (int unsigned s = 0; s < PfxSteps; s++) begin
      scan = scan | (scan << (1 << s));
    end
    pfx_d = en_i ? scan : pfx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pfx_q <= '0;
    end else begin
      pfx_q <= pfx_d;
    end
  end

  assign pfx_o = pfx_q;

endmodule

`default_nettype wire

[hw/rtl/integer_set_store_unit.sv]
// A request transferred while idle is held in the request register, then passes the cell
// match flags, the prefix register and the result register before valid_o goes high for
// its result, which is transferred at the clock edge that ends the valid_o cycle.
// A new request is taken only once the last has finished; busy stays high through the compare,
// prefix and update cycles of the cell row, and the result has no back-pressure.
// Reset: rst_ni clears the count and all cell valid bits at once; no clearing pass.
`default_nettype none

module integer_set_store_unit
  import isset_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire req_t req_i,
  output logic      busy,
  output logic      valid_o,
  output res_t      result_o
);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic   valid_q, valid_d;
  res_t   res_q, res_d;

  cell_ctrl_t          ctrl;
  logic [ElemW-1:0]    entry [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] pfx;

  logic present, room, is_ins, is_del, do_ins, do_del;

  assign present = pfx[CAPACITY-1];
  assign room    = !cell_valid[CAPACITY-1];
  assign is_ins  = (req_q.req_type == REQ_INSERT);
  assign is_del  = (req_q.req_type == REQ_DELETE);
  assign do_ins  = is_ins && !present && room;
  assign do_del  = is_del && present;

  // Sequencer: next state, cell controls and result.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    occ_d       = occ_q;
    valid_d     = 1'b0;
    res_d       = res_q;
    ctrl        = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = ST_PFX;
      end
      ST_PFX: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        ctrl.ins_en = do_ins;
        ctrl.del_en = is_del;
        if (do_ins) begin
          occ_d = occ_q + OccW'(1);
        end else if (do_del) begin
          occ_d = occ_q - OccW'(1);
        end
        valid_d            = 1'b1;
        res_d.was_present  = present;
        res_d.dropped_full = is_ins && !present && !room;
        res_d.count        = CountW'(occ_d);
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  // Row of entry cells; each cell sees its lower neighbor's valid bit and its upper neighbor's entry and valid bit.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             prev_valid;
    logic [ElemW-1:0] next_entry;
    logic             next_valid;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_entry = entry[i+1];
      assign next_valid = cell_valid[i+1];
    end

    isset_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .elem_i       (req_q.elem),
      .prev_valid_i (prev_valid),
      .next_entry_i (next_entry),
      .next_valid_i (next_valid),
      .shift_i      (pfx[i]),
      .entry_o      (entry[i]),
      .valid_o      (cell_valid[i]),
      .match_o      (match[i])
    );
  end

  // Prefix of the match flags selects the cells that close a deleted gap.
  isset_pfx u_pfx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (state_q == ST_PFX),
    .match_i (match),
    .pfx_o   (pfx)
  );

  assign busy     = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

[hw/rtl/isset_checker.sv]
`default_nettype none

module isset_checker
  import isset_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic valid_o,
  input wire res_t result_o
);

  // A transferred request is followed by its result strobe.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 valid_o)
    else $error("result strobe missing after request");

  // A result only follows a busy period.
  a_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result without preceding work");

  // Results are single strobes, one per request.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe repeated");

  // A dropped insert was of an absent value into a full set.
  a_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.dropped_full) |->
      (!result_o.was_present && (result_o.count == CountW'(CAPACITY))))
    else $error("dropped insert with inconsistent flags");

  // The count never exceeds the capacity.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.count <= CountW'(CountMax)))
    else $error("count above capacity");

endmodule

bind integer_set_store_unit isset_checker u_isset_checker (.*);

`default_nettype wire

[tb/tb_integer_set_store_unit.sv]
`default_nettype none

module tb_integer_set_store_unit;
  import isset_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The fourth request code is unused and behaves as a membership query.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned QuietLimit = 500;
  localparam int unsigned RandomItems = 1020;

  // One queued request, or a marker that holds the sender until the store is quiet.
  typedef struct {
    bit   wait_idle;
    req_t req;
  } pending_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic valid_o;
  res_t result_o;

  pending_req_t request_q[$];
  res_t         expected_q[$];
  logic [ElemW-1:0] value_pool[$];

  // Shadow copy of the set contents in insertion order.
  logic [ElemW-1:0] shadow_vals [CAPACITY];
  int unsigned      shadow_count = 0;

  logic        took_last = 1'b0;
  int unsigned idle_left = 0;
  int unsigned sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;

  integer_set_store_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .req_i    (req_i),
    .busy     (busy),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the shadow set and return the result it should give.
  function automatic res_t apply_request(input req_t rq);
    res_t        r;
    logic        found;
    int unsigned slot;
    int unsigned i;
    r = '0;
    found = 1'b0;
    slot = 0;
    for (i = 0; i < shadow_count; i++) begin
      if (!found && shadow_vals[i] == rq.elem) begin
        found = 1'b1;
        slot = i;
      end
    end
    case (rq.req_type)
      REQ_INSERT: begin
        if (!found) begin
          if (shadow_count < CAPACITY) begin
            shadow_vals[shadow_count] = rq.elem;
            shadow_count++;
          end else begin
            r.dropped_full = 1'b1;
          end
        end
      end
      REQ_DELETE: begin
        if (found) begin
          for (i = slot; i + 1 < shadow_count; i++) begin
            shadow_vals[i] = shadow_vals[i + 1];
          end
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    r.was_present = found;
    r.count = shadow_count[CountW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] result check: %s got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_req(input logic [1:0] kind, input logic [ElemW-1:0] v);
    pending_req_t p;
    p.wait_idle = 1'b0;
    p.req.req_type = kind;
    p.req.elem = v;
    request_q.push_back(p);
  endtask

  task automatic push_pause();
    pending_req_t p;
    p.wait_idle = 1'b1;
    p.req = '0;
    request_q.push_back(p);
  endtask

  function automatic logic [ElemW-1:0] any_pooled();
    return value_pool[$urandom_range(0, value_pool.size() - 1)];
  endfunction

  // Pick among the most recently used values, which are most likely still held.
  function automatic logic [ElemW-1:0] recent_pooled();
    int unsigned span;
    span = (value_pool.size() < 160) ? value_pool.size() : 160;
    return value_pool[value_pool.size() - 1 - $urandom_range(0, span - 1)];
  endfunction

  // Sender: one transfer per accepted request, with random idle stretches.
  always @(negedge clk_i) begin : sender
    pending_req_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took_last) begin
      // The request on the bus has not been taken yet; keep it.
    end else if (idle_left != 0) begin
      start <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (request_q.size() == 0) begin
      start <= 1'b0;
    end else if (request_q[0].wait_idle) begin
      start <= 1'b0;
      if (expected_q.size() == 0) begin
        void'(request_q.pop_front());
      end
    end else if (!(sent >= 400 && sent < 600) && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      idle_left <= $urandom_range(0, 5);
    end else begin
      nxt = request_q.pop_front();
      start <= 1'b1;
      req_i <= nxt.req;
      sent <= sent + 1;
    end
  end

  // Accept requests, predict their results and check every result strobe.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    if (!rst_ni) begin
      took_last <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      took_last <= start && !busy;
      if (valid_o) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, count", result_o.count, -1);
        end else begin
          want = expected_q.pop_front();
          if (result_o.was_present !== want.was_present) begin
            report_mismatch("was_present", result_o.was_present, want.was_present);
          end
          if (result_o.dropped_full !== want.dropped_full) begin
            report_mismatch("dropped_full", result_o.dropped_full, want.dropped_full);
          end
          if (result_o.count !== want.count) begin
            report_mismatch("count", result_o.count, want.count);
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back(apply_request(req_i));
      end
      // Watchdog on cycles without any transfer in either direction.
      if ((start && !busy) || valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("watchdog expired after %0d idle cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Build the request list, run it and judge the outcome.
  initial begin : stimulus
    logic [ElemW-1:0] v;
    int unsigned      k;
    logic [1:0]       kind;

    // Directed: extreme values, every request code and the corner cases.
    push_req(REQ_QUERY, 32'h0000_0000);
    push_req(REQ_INSERT, 32'h8000_0000);
    push_req(REQ_INSERT, 32'h7FFF_FFFF);
    push_req(REQ_INSERT, 32'h0000_0000);
    push_req(REQ_INSERT, 32'hFFFF_FFFF);
    push_req(REQ_INSERT, 32'h7FFF_FFFF);
    push_req(REQ_QUERY, 32'h8000_0000);
    push_req(REQ_UNUSED, 32'hFFFF_FFFF);
    push_req(REQ_UNUSED, 32'h0000_0005);
    push_req(REQ_DELETE, 32'h0000_0005);
    push_req(REQ_DELETE, 32'h8000_0000);
    push_req(REQ_QUERY, 32'h8000_0000);
    push_req(REQ_QUERY, 32'h7FFF_FFFF);
    push_req(REQ_DELETE, 32'hFFFF_FFFF);
    push_req(REQ_DELETE, 32'h0000_0000);
    push_req(REQ_DELETE, 32'h7FFF_FFFF);
    push_req(REQ_DELETE, 32'h7FFF_FFFF);
    push_req(REQ_INSERT, 32'h5555_5555);
    push_req(REQ_INSERT, 32'hAAAA_AAAA);
    push_req(REQ_QUERY, 32'hAAAA_AAAA);
    push_req(REQ_UNUSED, 32'h5555_5555);
    value_pool.push_back(32'h5555_5555);
    value_pool.push_back(32'hAAAA_AAAA);
    push_pause();

    // Random rounds: fill past capacity, churn at full, drain, then noise.
    k = 0;
    while (k < RandomItems) begin
      repeat (150) begin
        if ($urandom_range(0, 9) == 0) begin
          push_req(REQ_QUERY, any_pooled());
        end else begin
          v = $urandom();
          push_req(REQ_INSERT, v);
          value_pool.push_back(v);
        end
      end
      repeat (60) begin
        case ($urandom_range(0, 3))
          0: begin
            v = $urandom();
            push_req(REQ_INSERT, v);
            value_pool.push_back(v);
          end
          1: push_req(REQ_DELETE, recent_pooled());
          2: push_req(REQ_INSERT, recent_pooled());
          default: push_req(REQ_QUERY, recent_pooled());
        endcase
      end
      push_pause();
      for (int unsigned j = 0; j < 150; j++) begin
        if ($urandom_range(0, 4) != 0) begin
          push_req(REQ_DELETE, value_pool[value_pool.size() - 1 - (j % value_pool.size())]);
        end else begin
          push_req(REQ_QUERY, recent_pooled());
        end
      end
      repeat (150) begin
        kind = 2'($urandom_range(0, 3));
        v = ($urandom_range(0, 1) == 0) ? $urandom() : any_pooled();
        push_req(kind, v);
      end
      push_pause();
      k += 510;
    end

    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || start || expected_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
